// ===== src/dlrb_pkg.sv =====
// Package for the delimited line ring buffer.
// Shared widths, codes and the result transaction type; no dependencies.
package dlrb_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;

  // Store contents after reset
  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Result kind codes
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // Register indexes
  localparam logic REG_DELIMITER = 1'b0;

  // One result transaction
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [LEN_W-1:0]  count;
  } res_t;

endpackage

// ===== src/dlrb_store.sv =====
// Byte ring store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as newline. Uses dlrb_pkg.
module dlrb_store #(
  parameter int DEPTH = 64,
  parameter int PW    = 6
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [PW-1:0]              wr_addr,
  input  logic [dlrb_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [PW-1:0]              rd_addr,
  output logic [dlrb_pkg::BYTE_W-1:0] rd_data
);
  import dlrb_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [BYTE_W-1:0] rd_data_r;

  // Storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read; unwritten entries return newline
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : NEWLINE_BYTE;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/delimited_line_ring_buffer.sv =====
// Delimited line ring buffer: a DEPTH-byte ring store with wrapping write and read
// positions. A write item (cmd 0) stores at most one byte of a line; the item
// carrying line_end returns one count result. A read item (cmd 1) streams stored bytes
// from the read position, one result per byte, up to the delimiter or max_len bytes.
// A read holds the input stalled until its last byte has returned, so no new item is
// taken before the read ends; the store has a single synchronous read port with a
// registered read. A read with a zero length returns nothing. Output stalls slow
// the stream down. After reset the store reads as newline bytes at once (per-entry
// valid bits, no clearing pass). The delimiter register (reset 0x0A) sits at address
// 0 of the APB port; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module delimited_line_ring_buffer #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [dlrb_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                        in_line_end,
  input  logic [dlrb_pkg::LEN_W-1:0]  in_max_len,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kind,
  output logic [dlrb_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last,
  output logic [dlrb_pkg::LEN_W-1:0]  out_count,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [2:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import dlrb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0]    LAST_POS  = PW'(DEPTH - 1);
  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(DEPTH);

  // ---------------- configuration ----------------
  logic [BYTE_W-1:0] delim_r;
  logic              cfg_wr;
  logic              cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_idx == REG_DELIMITER) ? {24'd0, delim_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= NEWLINE_BYTE;
    end else if (cfg_wr && cfg_idx == REG_DELIMITER) begin
      delim_r <= cfg_pwdata[BYTE_W-1:0];
    end
  end

  // ---------------- state ----------------
  logic [PW-1:0]    wr_pos_r, wr_pos_nxt;
  logic [PW-1:0]    rd_pos_r, rd_pos_nxt;
  logic [LEN_W-1:0] line_cnt_r, line_cnt_nxt;
  logic             closed_r, closed_nxt;
  logic             rd_active_r, rd_active_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic [LEN_W-1:0] limit_r, limit_nxt;
  logic [LEN_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [LEN_W-1:0] ret_cnt_r, ret_cnt_nxt;

  // output register plus skid slot
  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;

  // ---------------- datapath signals ----------------
  logic              in_acc;
  logic [LEN_W-1:0]  in_limit;
  logic              wr_store;
  logic [BYTE_W-1:0] rd_data;
  logic [LEN_W-1:0]  ret_k;
  logic              ret_last;
  logic              iss_go;
  logic              pop;
  logic              push_v;
  res_t              push_d;

  assign in_stall = rd_active_r || skid_v_r;
  assign in_acc   = in_valid && !in_stall;
  assign in_limit = (in_max_len > DEPTH_LEN) ? DEPTH_LEN : in_max_len;
  assign wr_store = in_acc && (in_cmd == CMD_WRITE) && !closed_r && (line_cnt_r < in_limit);

  // Returning read byte
  assign ret_k    = ret_cnt_r + LEN_W'(1);
  assign ret_last = rd_v_r && ((rd_data == delim_r) || (ret_k == limit_r));

  assign pop = out_v_r && !out_stall;

  // Issue a read only if the skid slot is sure to be free when the data lands
  assign iss_go = rd_active_r && !ret_last && (iss_cnt_r < limit_r) && !skid_v_r &&
                  !(rd_v_r && out_v_r && out_stall);

  dlrb_store #(
    .DEPTH (DEPTH),
    .PW    (PW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_store),
    .wr_addr (wr_pos_r),
    .wr_data (in_data_byte),
    .rd_en   (iss_go),
    .rd_addr (rd_pos_r),
    .rd_data (rd_data)
  );

  // ---------------- write line and read engine ----------------
  always_comb begin
    wr_pos_nxt    = wr_pos_r;
    rd_pos_nxt    = rd_pos_r;
    line_cnt_nxt  = line_cnt_r;
    closed_nxt    = closed_r;
    rd_active_nxt = rd_active_r;
    limit_nxt     = limit_r;
    iss_cnt_nxt   = iss_cnt_r;
    ret_cnt_nxt   = ret_cnt_r;
    rd_v_nxt      = iss_go;
    push_v        = 1'b0;
    push_d        = '{kind: KIND_COUNT, data: '0, last: 1'b1, count: '0};

    // write transaction
    if (in_acc && in_cmd == CMD_WRITE) begin
      if (wr_store) begin
        wr_pos_nxt   = (wr_pos_r == LAST_POS) ? '0 : wr_pos_r + PW'(1);
        line_cnt_nxt = line_cnt_r + LEN_W'(1);
        if (in_data_byte == delim_r) begin
          closed_nxt = 1'b1;
        end
      end
      if (in_line_end) begin
        push_v       = 1'b1;
        push_d.count = line_cnt_nxt;
        line_cnt_nxt = '0;
        closed_nxt   = 1'b0;
      end
    end

    // read transaction start; a zero limit yields nothing
    if (in_acc && in_cmd == CMD_READ && in_limit != '0) begin
      rd_active_nxt = 1'b1;
      limit_nxt     = in_limit;
      iss_cnt_nxt   = '0;
      ret_cnt_nxt   = '0;
    end

    // read issue
    if (iss_go) begin
      rd_pos_nxt  = (rd_pos_r == LAST_POS) ? '0 : rd_pos_r + PW'(1);
      iss_cnt_nxt = iss_cnt_r + LEN_W'(1);
    end

    // read return
    if (rd_v_r) begin
      ret_cnt_nxt = ret_k;
      push_v      = 1'b1;
      push_d      = '{kind: KIND_BYTE, data: rd_data, last: ret_last,
                      count: ret_last ? ret_k : '0};
      if (ret_last) begin
        rd_active_nxt = 1'b0;
      end
    end
  end

  // ---------------- output register and skid ----------------
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push_v) begin
      if (!out_v_r || pop) begin
        out_nxt   = push_d;
        out_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_d;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r    <= '0;
      rd_pos_r    <= '0;
      line_cnt_r  <= '0;
      closed_r    <= 1'b0;
      rd_active_r <= 1'b0;
      rd_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      skid_v_r    <= 1'b0;
      iss_cnt_r   <= '0;
      ret_cnt_r   <= '0;
    end else begin
      wr_pos_r    <= wr_pos_nxt;
      rd_pos_r    <= rd_pos_nxt;
      line_cnt_r  <= line_cnt_nxt;
      closed_r    <= closed_nxt;
      rd_active_r <= rd_active_nxt;
      rd_v_r      <= rd_v_nxt;
      out_v_r     <= out_v_nxt;
      skid_v_r    <= skid_v_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      ret_cnt_r   <= ret_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    out_r   <= out_nxt;
    skid_r  <= skid_nxt;
  end

  assign out_valid = out_v_r;
  assign out_kind  = out_r.kind;
  assign out_byte  = out_r.data;
  assign out_last  = out_r.last;
  assign out_count = out_r.count;

  // ---------------- assertions ----------------
  // A full skid slot never meets a new result
  a_no_push_on_full_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> !push_v)
    else $error("result pushed while skid slot full");

  // Read data only returns while a read line is open
  a_return_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> rd_active_r)
    else $error("read data returned outside a read line");

  // Issued reads never exceed the line limit
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_active_r |-> (iss_cnt_r <= limit_r && ret_cnt_r <= iss_cnt_r))
    else $error("read issue count out of range");

  // The final byte of a read line closes the engine
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    ret_last |=> !rd_active_r && !rd_v_r)
    else $error("read engine still open after final byte");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for delimited_line_ring_buffer.
// Depends on dlrb_pkg and the block's RTL. Predicts each result from its own model of
// the ring and checks every output transaction in order.
module testbench;
  import dlrb_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 20;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_ERROR_LINES = 30;
  // Byte address of register index 1, which does not exist
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  logic clk = 1'b0;
  logic rst_n;

  logic              in_valid;
  logic              in_stall;
  logic              in_cmd;
  logic [BYTE_W-1:0] in_data_byte;
  logic              in_line_end;
  logic [LEN_W-1:0]  in_max_len;

  logic              out_valid;
  logic              out_stall;
  logic              out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic [LEN_W-1:0]  out_count;

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [2:0]        cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // Shadow of the ring and its positions
  logic [BYTE_W-1:0] ring_image [DEPTH];
  logic [5:0]        wr_ptr;
  logic [5:0]        rd_ptr;
  int                line_len;
  bit                line_done;
  logic [BYTE_W-1:0] delim_reg;

  res_t pending_results [$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_req;
  int  hold_left = 0;

  delimited_line_ring_buffer #(.DEPTH(DEPTH)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .in_line_end  (in_line_end),
    .in_max_len   (in_max_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_count    (out_count),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  // Clock: 1 ns high, 1 ns low
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_ERROR_LINES)
      $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_req <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result checker: oldest expectation first
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{kind: out_kind, data: out_byte, last: out_last, count: out_count};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d byte=%02h last=%0d count=%0d",
                                  got.kind, got.data, got.last, got.count));
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("out_kind %0d, expected %0d", got.kind, want.kind));
        if (got.data !== want.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", got.data, want.data));
        if (got.last !== want.last)
          report_mismatch($sformatf("out_last %0d, expected %0d", got.last, want.last));
        if (got.count !== want.count)
          report_mismatch($sformatf("out_count %0d, expected %0d", got.count, want.count));
      end
    end
  end

  // Expected results of one accepted input transaction
  task automatic predict_line_results(input logic cmd, input logic [BYTE_W-1:0] b,
                                      input logic le, input logic [LEN_W-1:0] ml);
    int lim;
    int k;
    bit done;
    logic [BYTE_W-1:0] v;
    res_t r;
    lim = (ml > DEPTH) ? DEPTH : int'(ml);
    if (cmd == CMD_WRITE) begin
      if (!line_done && line_len < lim) begin
        ring_image[wr_ptr] = b;
        wr_ptr++;
        line_len++;
        if (b == delim_reg) line_done = 1'b1;
      end
      if (le) begin
        r = '{kind: KIND_COUNT, data: '0, last: 1'b1, count: LEN_W'(line_len)};
        pending_results.push_back(r);
        line_len = 0;
        line_done = 1'b0;
      end
    end else begin
      k = 0;
      done = 1'b0;
      while (!done && k < lim) begin
        v = ring_image[rd_ptr];
        rd_ptr++;
        k++;
        done = (v == delim_reg);
        r = '{kind: KIND_BYTE, data: v, last: 1'b0, count: '0};
        if (done || k == lim) begin
          r.last = 1'b1;
          r.count = LEN_W'(k);
        end
        pending_results.push_back(r);
      end
    end
  endtask

  // Offer one input transaction and wait until it is taken
  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b,
                           input logic le, input logic [LEN_W-1:0] ml);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= b;
    in_line_end  <= le;
    in_max_len   <= ml;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_line_results(cmd, b, le, ml);
  endtask

  // Stop sending and let every outstanding result drain
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // APB transfer: setup, access, then back to idle
  task automatic cfg_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_delimiter_readback();
    logic [31:0] rd;
    cfg_access(1'b0, {REG_DELIMITER, 2'b00}, '0, rd);
    if (rd[BYTE_W-1:0] !== delim_reg)
      report_mismatch($sformatf("delimiter reads %02h, expected %02h",
                                rd[BYTE_W-1:0], delim_reg));
  endtask

  task automatic set_delimiter(input logic [BYTE_W-1:0] value);
    logic [31:0] rd;
    wait_idle(SETTLE_CYCLES);
    cfg_access(1'b1, {REG_DELIMITER, 2'b00}, {24'h0, value}, rd);
    delim_reg = value;
    check_delimiter_readback();
  endtask

  // Mostly short lengths, some up to the ring size, some beyond it, a few zero
  function automatic logic [LEN_W-1:0] pick_max_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return LEN_W'($urandom_range(1, 16));
    if (p < 85) return LEN_W'($urandom_range(17, 64));
    if (p < 95) return LEN_W'($urandom_range(65, 127));
    return '0;
  endfunction

  // Directed cases with the reset delimiter (newline)
  task automatic test_directed();
    // Extremes of the byte, cap above the ring size, delimiter ends the line
    send_item(CMD_WRITE, 8'h41, 1'b0, 7'd64);
    send_item(CMD_WRITE, 8'h00, 1'b0, 7'd64);
    send_item(CMD_WRITE, 8'hFF, 1'b0, 7'd127);
    send_item(CMD_WRITE, NEWLINE_BYTE, 1'b1, 7'd64);
    // Zero max length: write drops the byte but still counts, read returns nothing
    send_item(CMD_WRITE, 8'h55, 1'b1, 7'd0);
    send_item(CMD_READ, 8'hA5, 1'b1, 7'd0);
    send_item(CMD_READ, 8'h00, 1'b0, 7'd127);
    // Max length changing within a line
    send_item(CMD_WRITE, 8'h11, 1'b0, 7'd1);
    send_item(CMD_WRITE, 8'h22, 1'b0, 7'd1);
    send_item(CMD_WRITE, 8'h33, 1'b0, 7'd3);
    send_item(CMD_WRITE, 8'h44, 1'b1, 7'd2);
    // Bytes after the delimiter are dropped
    send_item(CMD_WRITE, NEWLINE_BYTE, 1'b0, 7'd8);
    send_item(CMD_WRITE, 8'h66, 1'b1, 7'd8);
    // Open line with a read in between
    send_item(CMD_WRITE, 8'h77, 1'b0, 7'd5);
    send_item(CMD_READ, 8'hFF, 1'b0, 7'd3);
    send_item(CMD_WRITE, NEWLINE_BYTE, 1'b1, 7'd5);
    send_item(CMD_READ, 8'h00, 1'b1, 7'd64);
    send_item(CMD_READ, 8'h00, 1'b0, 7'd1);
    send_item(CMD_READ, 8'h00, 1'b0, 7'd2);
  endtask

  // Read wrapping past the end of the ring with no delimiter in the store
  task automatic test_read_wrap();
    set_delimiter(8'hEE);
    send_item(CMD_READ, 8'h00, 1'b0, 7'd127);
    send_item(CMD_READ, 8'h00, 1'b0, 7'd64);
  endtask

  // Writes to a register index beyond zero must leave the delimiter alone
  task automatic test_ignored_register();
    logic [31:0] rd;
    wait_idle(SETTLE_CYCLES);
    cfg_access(1'b1, ADDR_UNUSED, $urandom, rd);
    check_delimiter_readback();
    send_item(CMD_WRITE, 8'h5A, 1'b0, 7'd64);
    send_item(CMD_WRITE, delim_reg, 1'b1, 7'd64);
    send_item(CMD_READ, 8'h00, 1'b0, 7'd64);
  endtask

  // Long receiver hold-off while lines and reads keep coming
  task automatic test_backpressure();
    int i;
    int j;
    hold_req <= 1'b1;
    for (i = 0; i < 6; i++) begin
      for (j = 0; j < 4; j++)
        send_item(CMD_WRITE, BYTE_W'($urandom_range(0, 255)), 1'b0, 7'd64);
      send_item(CMD_WRITE, delim_reg, 1'b1, 7'd64);
      send_item(CMD_READ, 8'h00, 1'b0, 7'd64);
    end
  endtask

  // Mostly well-formed lines and reads, with some raw noise
  task automatic test_random_traffic(input int n_items);
    int sent;
    int pick;
    int len;
    int i;
    logic [LEN_W-1:0] ml;
    logic [BYTE_W-1:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 10);
        ml = pick_max_len();
        for (i = 0; i < len; i++) begin
          b = BYTE_W'($urandom_range(0, 255));
          if (i == len - 1 && $urandom_range(0, 99) < 60) b = delim_reg;
          else if ($urandom_range(0, 99) < 4) b = delim_reg;
          if ($urandom_range(0, 9) == 0) ml = pick_max_len();
          send_item(CMD_WRITE, b, i == len - 1, ml);
          sent++;
        end
      end else if (pick < 85) begin
        send_item(CMD_READ, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  pick_max_len());
        sent++;
      end else begin
        send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 127)));
        sent++;
      end
    end
  endtask

  initial begin
    int i;
    // Known values on every input before the first edge
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_cmd       <= CMD_WRITE;
    in_data_byte <= '0;
    in_line_end  <= 1'b0;
    in_max_len   <= '0;
    out_stall    <= 1'b0;
    hold_req     <= 1'b0;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;

    for (i = 0; i < DEPTH; i++) ring_image[i] = NEWLINE_BYTE;
    wr_ptr = '0;
    rd_ptr = '0;
    line_len = 0;
    line_done = 1'b0;
    delim_reg = NEWLINE_BYTE;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles lightly, receiver heavily
    send_idle_pct = 36;
    recv_idle_pct = 82;
    check_delimiter_readback();
    test_directed();
    test_read_wrap();
    set_delimiter(8'h00);
    test_random_traffic(120);
    test_backpressure();

    // Roles swapped
    send_idle_pct = 82;
    recv_idle_pct = 36;
    test_ignored_register();
    set_delimiter(8'hFF);
    test_random_traffic(120);

    // No idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_delimiter(BYTE_W'($urandom_range(1, 254)));
    test_random_traffic(110);

    wait_idle(DRAIN_CYCLES);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
